### hw/rtl/sfti_pkg.sv
// ---------------------------------------------------------------------------
// sfti_pkg: shared types and constants
// Node word, result word, centre registers and queue sizing for the surface
// force and torque integrator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfti_pkg;

	// default fractional bits of the fixed-point formats
	localparam int FRAC_BITS_DEF = 16;

	// field widths
	localparam int VAL_W = 32;
	localparam int SUM_W = 48;

	// stream data widths
	localparam int IN_DATA_W  = 7 * VAL_W;
	localparam int OUT_DATA_W = 6 * SUM_W;

	// node queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X = 2'd0,
		REG_CENTER_Y = 2'd1,
		REG_CENTER_Z = 2'd2
	} cfg_reg_t;

	// one surface node, last field in the lowest bits
	typedef struct packed {
		logic                    last;
		logic signed [VAL_W-1:0] point_z;
		logic signed [VAL_W-1:0] point_y;
		logic signed [VAL_W-1:0] point_x;
		logic        [VAL_W-1:0] area_weight;
		logic signed [VAL_W-1:0] traction_z;
		logic signed [VAL_W-1:0] traction_y;
		logic signed [VAL_W-1:0] traction_x;
	} node_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		node_t node;
	} qhead_t;

	// centre of mass registers
	typedef struct packed {
		logic signed [VAL_W-1:0] z;
		logic signed [VAL_W-1:0] y;
		logic signed [VAL_W-1:0] x;
	} center_t;

	// one result word, last field in the lowest bits
	typedef struct packed {
		logic signed [SUM_W-1:0] torque_z;
		logic signed [SUM_W-1:0] torque_y;
		logic signed [SUM_W-1:0] torque_x;
		logic signed [SUM_W-1:0] force_z;
		logic signed [SUM_W-1:0] force_y;
		logic signed [SUM_W-1:0] force_x;
	} result_t;

endpackage

### hw/rtl/surface_force_torque_integrator.sv
// ---------------------------------------------------------------------------
// surface_force_torque_integrator: nodal force and torque accumulation
// Sums weighted surface tractions and their moments about a centre of mass.
// ---------------------------------------------------------------------------
// Usage:
//   s_* stream carries one surface node per word: traction, area weight and
//   position in tdata, with s_tlast on the final node of a mesh.
//   m_* stream carries one word per mesh: summed force and torque, given on
//   the word that closed the mesh. Nodes without tlast give no word.
//   The APB port holds the centre of mass x, y, z at 0x0, 0x4, 0x8; write it
//   only while no mesh is in flight.
// Timing:
//   one node per cycle sustained while no result waits on m_tready, set by the
//   saturating accumulate at the end of the five-stage back-end pipeline.
//   a last node's sums reach m_* after it passes the queue, s1 to s4 and res_q.
//   a four-word node queue sits between intake and pipeline.
// Reset and stall:
//   reset empties the queue and pipeline and clears sums and centre.
//   while a result waits on m_tready the pipeline holds; the queue keeps
//   taking nodes until full, then s_tready drops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module surface_force_torque_integrator #(
	parameter int FRAC_BITS = sfti_pkg::FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// traction_x, traction_y, traction_z, area_weight, point_x, point_y, point_z
	input  logic [sfti_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                             s_tlast,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// force_x, force_y, force_z, torque_x, torque_y, torque_z
	output logic [sfti_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [3:0]                       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import sfti_pkg::*;

	center_t  center_q;
	qhead_t   head;
	logic     pop;
	result_t  res;
	logic     cfg_wr;
	cfg_reg_t cfg_idx;

	// configuration registers
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = cfg_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_CENTER_X: center_q.x <= pwdata;
				REG_CENTER_Y: center_q.y <= pwdata;
				REG_CENTER_Z: center_q.z <= pwdata;
				default:      center_q   <= center_q;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (cfg_idx)
			REG_CENTER_X: prdata = center_q.x;
			REG_CENTER_Y: prdata = center_q.y;
			REG_CENTER_Z: prdata = center_q.z;
			default:      prdata = '0;
		endcase
	end

	// node intake
	sfti_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (s_tvalid),
		.ready  (s_tready),
		.node   (node_t'({s_tlast, s_tdata})),
		.head   (head),
		.pop    (pop)
	);

	// force and torque pipeline
	sfti_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.center    (center_q),
		.head      (head),
		.pop       (pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = res;

endmodule

### hw/rtl/sfti_front.sv
// ---------------------------------------------------------------------------
// sfti_front: node intake and queue
// Accepts node words from the input stream into a small queue and presents
// the oldest one to the back end, which pops it when its pipeline advances.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfti_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            ready,
	input  sfti_pkg::node_t node,
	output sfti_pkg::qhead_t head,
	input  logic            pop
);
	import sfti_pkg::*;

	node_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              wr_en;
	logic              rd_en;

	// handshake
	assign ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign wr_en = push && ready;
	assign rd_en = pop && (cnt_q != '0);

	// head of queue
	assign head.valid = (cnt_q != '0);
	assign head.node  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= node;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hw/rtl/sfti_back.sv
// ---------------------------------------------------------------------------
// sfti_back: force and torque pipeline
// Five-stage pipeline: nodal force products and lever, rounding, cross
// products, rounded differences, saturating accumulate into the output word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfti_back #(
	parameter int FRAC_BITS = sfti_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sfti_pkg::center_t            center,
	input  sfti_pkg::qhead_t             head,
	output logic                         pop,
	output logic                         res_valid,
	input  logic                         res_ready,
	output sfti_pkg::result_t            res
);
	import sfti_pkg::*;

	// product, rounded, difference and accumulate widths
	localparam int PW = 2 * VAL_W + 1;
	localparam int BW = PW + 1;
	localparam int RW = BW - FRAC_BITS;
	localparam int DW = RW + 1;
	localparam int AW = ((DW > SUM_W) ? DW : SUM_W) + 1;
	localparam logic signed [BW-1:0] RBIAS = BW'(1) << (FRAC_BITS - 1);

	// round half up after dropping the fraction
	function automatic logic signed [RW-1:0] rnd(input logic signed [PW-1:0] v);
		logic signed [BW-1:0] b;
		b   = {v[PW-1], v} + RBIAS;
		rnd = RW'(b >>> FRAC_BITS);
	endfunction

	// clamp to 32 bits
	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [RW-1:0] v);
		logic [RW-VAL_W:0] hi;
		hi = v[RW-1:VAL_W-1];
		if ((&hi) || !(|hi)) begin
			sat32 = v[VAL_W-1:0];
		end else if (v[RW-1]) begin
			sat32 = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			sat32 = {1'b0, {(VAL_W-1){1'b1}}};
		end
	endfunction

	// clamp to 48 bits
	function automatic logic signed [SUM_W-1:0] sat48(input logic signed [AW-1:0] v);
		logic [AW-SUM_W:0] hi;
		hi = v[AW-1:SUM_W-1];
		if ((&hi) || !(|hi)) begin
			sat48 = v[SUM_W-1:0];
		end else if (v[AW-1]) begin
			sat48 = {1'b1, {(SUM_W-1){1'b0}}};
		end else begin
			sat48 = {1'b0, {(SUM_W-1){1'b1}}};
		end
	endfunction

	logic adv;

	logic                    v_s1, v_s2, v_s3, v_s4;
	logic                    last_s1, last_s2, last_s3, last_s4;
	logic signed [PW-1:0]    fp_s1 [3];
	logic signed [VAL_W:0]   r_s1 [3];
	logic signed [VAL_W-1:0] f_s2 [3];
	logic signed [VAL_W:0]   r_s2 [3];
	logic signed [VAL_W-1:0] f_s3 [3];
	logic signed [PW-1:0]    cp_s3 [6];
	logic signed [RW-1:0]    cp_rnd [6];
	logic signed [VAL_W-1:0] f_s4 [3];
	logic signed [DW-1:0]    d_s4 [3];
	logic signed [SUM_W-1:0] fsum_q [3];
	logic signed [SUM_W-1:0] tsum_q [3];
	logic signed [SUM_W-1:0] fnew [3];
	logic signed [SUM_W-1:0] tnew [3];
	logic                    res_valid_q;
	result_t                 res_q;
	logic                    load_res;

	logic        [VAL_W-1:0] w_in;
	logic signed [VAL_W-1:0] t_in [3];
	logic signed [VAL_W-1:0] p_in [3];
	logic signed [VAL_W-1:0] c_in [3];

	// the whole pipeline holds while a result waits
	assign adv      = !(res_valid_q && !res_ready);
	assign pop      = adv && head.valid;
	assign load_res = adv && v_s4 && last_s4;

	assign w_in    = head.node.area_weight;
	assign t_in[0] = head.node.traction_x;
	assign t_in[1] = head.node.traction_y;
	assign t_in[2] = head.node.traction_z;
	assign p_in[0] = head.node.point_x;
	assign p_in[1] = head.node.point_y;
	assign p_in[2] = head.node.point_z;
	assign c_in[0] = center.x;
	assign c_in[1] = center.y;
	assign c_in[2] = center.z;

	// rounded cross product terms
	always_comb begin
		for (int k = 0; k < 6; k++) begin
			cp_rnd[k] = rnd(cp_s3[k]);
		end
	end

	// stage datapath
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: weight times traction, lever about the centre
			for (int i = 0; i < 3; i++) begin
				fp_s1[i] <= $signed({1'b0, w_in}) * $signed({t_in[i][VAL_W-1], t_in[i]});
				r_s1[i]  <= $signed({p_in[i][VAL_W-1], p_in[i]})
				          - $signed({c_in[i][VAL_W-1], c_in[i]});
			end
			last_s1 <= head.node.last;
			// s2: nodal force rounded and clamped
			for (int i = 0; i < 3; i++) begin
				f_s2[i] <= sat32(rnd(fp_s1[i]));
				r_s2[i] <= r_s1[i];
			end
			last_s2 <= last_s1;
			// s3: cross product terms
			cp_s3[0] <= r_s2[1] * $signed({f_s2[2][VAL_W-1], f_s2[2]});
			cp_s3[1] <= r_s2[2] * $signed({f_s2[1][VAL_W-1], f_s2[1]});
			cp_s3[2] <= r_s2[2] * $signed({f_s2[0][VAL_W-1], f_s2[0]});
			cp_s3[3] <= r_s2[0] * $signed({f_s2[2][VAL_W-1], f_s2[2]});
			cp_s3[4] <= r_s2[0] * $signed({f_s2[1][VAL_W-1], f_s2[1]});
			cp_s3[5] <= r_s2[1] * $signed({f_s2[0][VAL_W-1], f_s2[0]});
			for (int i = 0; i < 3; i++) begin
				f_s3[i] <= f_s2[i];
			end
			last_s3 <= last_s2;
			// s4: each term rounded on its own, then subtracted
			for (int i = 0; i < 3; i++) begin
				d_s4[i] <= $signed({cp_rnd[2*i][RW-1], cp_rnd[2*i]})
				         - $signed({cp_rnd[2*i+1][RW-1], cp_rnd[2*i+1]});
				f_s4[i] <= f_s3[i];
			end
			last_s4 <= last_s3;
		end
	end

	// saturating sums
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fnew[i] = sat48(AW'({{(AW-SUM_W){fsum_q[i][SUM_W-1]}}, fsum_q[i]})
			        + AW'({{(AW-VAL_W){f_s4[i][VAL_W-1]}}, f_s4[i]}));
			tnew[i] = sat48(AW'({{(AW-SUM_W){tsum_q[i][SUM_W-1]}}, tsum_q[i]})
			        + AW'({{(AW-DW){d_s4[i][DW-1]}}, d_s4[i]}));
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q.force_x  <= fnew[0];
			res_q.force_y  <= fnew[1];
			res_q.force_z  <= fnew[2];
			res_q.torque_x <= tnew[0];
			res_q.torque_y <= tnew[1];
			res_q.torque_z <= tnew[2];
		end
	end

	// stage valids, sums and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				fsum_q[i] <= '0;
				tsum_q[i] <= '0;
			end
		end else begin
			if (adv) begin
				v_s1 <= head.valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				if (v_s4) begin
					for (int i = 0; i < 3; i++) begin
						fsum_q[i] <= last_s4 ? '0 : fnew[i];
						tsum_q[i] <= last_s4 ? '0 : tnew[i];
					end
				end
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// sums start over after a result is loaded
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |=> (fsum_q[0] == '0) && (tsum_q[2] == '0))
		else $error("sums not cleared after last node");

	// a stalled pipeline keeps its last stage
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s4) && $stable(last_s4))
		else $error("pipeline moved during output stall");

	// a result only appears for a last node
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(v_s4 && last_s4))
		else $error("result without last node");

endmodule

### sim/tb_surface_force_torque_integrator.sv
// ---------------------------------------------------------------------------
// tb_surface_force_torque_integrator: self-checking bench
// Streams surface nodes into the integrator under several centre-of-mass
// settings, predicts the summed force and torque of every mesh, and checks
// each result word field by field against the prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_surface_force_torque_integrator;

	import sfti_pkg::*;

	localparam int FRAC            = FRAC_BITS_DEF;
	localparam int N_PHASES        = 6;
	localparam int ITEMS_PER_PHASE = 306;
	localparam int HOLD_CYCLES     = 80;
	localparam int HOLD_ITEMS      = 40;
	localparam int DRAIN_CYCLES    = 16;
	localparam int STALL_LIMIT     = 1000;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	localparam logic [31:0] ONE  = 32'h0001_0000;
	localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
	localparam logic [31:0] MINV = 32'h8000_0000;
	localparam logic [31:0] WMAX = 32'hFFFF_FFFF;

	// centre of mass per phase; the random phase overrides its row
	localparam int RAND_PHASE = 3;
	localparam logic [31:0] CENTER_SETS [N_PHASES][3] = '{
		'{MAXV, MAXV, MAXV},
		'{MINV, MINV, MINV},
		'{MAXV, MINV, 32'h0000_0000},
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
		'{32'h0001_8000, 32'hFFFE_4000, 32'h0000_0100},
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000}
	};

	typedef struct {
		node_t   nd;
		bit      typed;
		result_t res;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	// traction_x, traction_y, traction_z, area_weight, point_x, point_y, point_z
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tlast;
	logic                  s_tvalid;
	logic                  s_tready;
	// force_x, force_y, force_z, torque_x, torque_y, torque_z
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [3:0]            paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	// predictor state
	longint  force_acc [3];
	longint  torque_acc [3];
	longint  center_pos [3];
	result_t expected_sums [$];
	dir_row_t dir_tab [$];

	string sum_names [6] = '{"force_x", "force_y", "force_z",
		"torque_x", "torque_y", "torque_z"};

	int n_mismatch = 0;
	bit no_idle    = 1'b0;
	bit hold_req   = 1'b0;

	surface_force_torque_integrator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// round half up back to the fixed-point format
	function automatic longint rnd_shift(input longint v);
		return (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
	endfunction

	function automatic longint clamp_bits(input longint v, input int bits);
		longint hi;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		if (v > hi)
			return hi;
		if (v < -hi - 1)
			return -hi - 1;
		return v;
	endfunction

	// accumulate one node; returns 1 with the sums when the node closes a mesh
	function automatic bit integrate_node(input node_t nd, output result_t res);
		longint w;
		longint tr [3];
		longint pt [3];
		longint f [3];
		longint r [3];
		longint d [3];
		int i;
		w     = longint'({32'b0, nd.area_weight});
		tr[0] = longint'($signed(nd.traction_x));
		tr[1] = longint'($signed(nd.traction_y));
		tr[2] = longint'($signed(nd.traction_z));
		pt[0] = longint'($signed(nd.point_x));
		pt[1] = longint'($signed(nd.point_y));
		pt[2] = longint'($signed(nd.point_z));
		for (i = 0; i < 3; i++) begin
			f[i] = clamp_bits(rnd_shift(w * tr[i]), VAL_W);
			r[i] = pt[i] - center_pos[i];
		end
		// lever cross force, each term rounded on its own
		d[0] = rnd_shift(r[1] * f[2]) - rnd_shift(r[2] * f[1]);
		d[1] = rnd_shift(r[2] * f[0]) - rnd_shift(r[0] * f[2]);
		d[2] = rnd_shift(r[0] * f[1]) - rnd_shift(r[1] * f[0]);
		for (i = 0; i < 3; i++) begin
			force_acc[i]  = clamp_bits(force_acc[i] + f[i], SUM_W);
			torque_acc[i] = clamp_bits(torque_acc[i] + d[i], SUM_W);
		end
		res = '0;
		if (!nd.last)
			return 1'b0;
		res.force_x  = force_acc[0][SUM_W-1:0];
		res.force_y  = force_acc[1][SUM_W-1:0];
		res.force_z  = force_acc[2][SUM_W-1:0];
		res.torque_x = torque_acc[0][SUM_W-1:0];
		res.torque_y = torque_acc[1][SUM_W-1:0];
		res.torque_z = torque_acc[2][SUM_W-1:0];
		for (i = 0; i < 3; i++) begin
			force_acc[i]  = 0;
			torque_acc[i] = 0;
		end
		return 1'b1;
	endfunction

	function automatic node_t mk_node(input logic [31:0] tx, ty, tz, w, px, py, pz,
			input logic lst);
		node_t nd;
		nd.traction_x  = tx;
		nd.traction_y  = ty;
		nd.traction_z  = tz;
		nd.area_weight = w;
		nd.point_x     = px;
		nd.point_y     = py;
		nd.point_z     = pz;
		nd.last        = lst;
		return nd;
	endfunction

	function automatic result_t mk_res(input logic [47:0] fx, fy, fz, qx, qy, qz);
		result_t res;
		res.force_x  = fx;
		res.force_y  = fy;
		res.force_z  = fz;
		res.torque_x = qx;
		res.torque_y = qy;
		res.torque_z = qz;
		return res;
	endfunction

	// signed value biased toward extremes and small magnitudes
	function automatic logic [31:0] rand_val();
		int lo;
		case ($urandom_range(0, 9))
			0: return MAXV;
			1: return MINV;
			2: return 32'h0000_0000;
			3, 4, 5: begin
				lo = $urandom_range(0, 32'h000C_0000);
				return lo - 32'sh0006_0000;
			end
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] rand_weight();
		case ($urandom_range(0, 9))
			0: return WMAX;
			1: return 32'h0000_0000;
			2: return ONE;
			3, 4, 5: return $urandom_range(0, 32'h0003_0000);
			default: return $urandom();
		endcase
	endfunction

	// offer one node word, with an occasional gap before it
	task automatic send_node(input node_t nd, input bit typed, input result_t typed_res);
		result_t res;
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tdata  <= nd[IN_DATA_W-1:0];
		s_tlast  <= nd.last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (integrate_node(nd, res))
			expected_sums.push_back(typed ? typed_res : res);
	endtask

	// stop offering and let every outstanding result come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_sums.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// apb write: setup, access, then idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_CENTER_X: center_pos[0] = longint'($signed(val));
			REG_CENTER_Y: center_pos[1] = longint'($signed(val));
			REG_CENTER_Z: center_pos[2] = longint'($signed(val));
			default: ;
		endcase
	endtask

	// result checking and receiver stalls
	initial begin
		result_t got;
		result_t want;
		int run;
		int i;
		bit rdy;
		m_tready = 1'b0;
		run = 0;
		rdy = 1'b1;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata);
				if (expected_sums.size() == 0) begin
					$error("result word with no mesh pending");
					n_mismatch++;
				end else begin
					want = expected_sums.pop_front();
					for (i = 0; i < 6; i++)
						if (got[i*SUM_W +: SUM_W] !== want[i*SUM_W +: SUM_W]) begin
							$error("%s: expected %0d, actual %0d", sum_names[i],
								$signed(want[i*SUM_W +: SUM_W]),
								$signed(got[i*SUM_W +: SUM_W]));
							n_mismatch++;
						end
				end
			end
			// ready runs, short stall bursts, one long hold on request
			if (no_idle) begin
				rdy = 1'b1;
				run = 0;
			end else if (run > 0) begin
				run--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				rdy = 1'b0;
				run = HOLD_CYCLES;
			end else begin
				rdy = $urandom_range(0, 2) != 0;
				run = rdy ? $urandom_range(1, 20) : $urandom_range(1, 10);
			end
			m_tready <= rdy;
		end
	end

	// watchdog on cycles without any word moving
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	// stimulus
	initial begin
		int p;
		int sent;
		int len;
		int j;
		bit paused;
		node_t nd;
		arst_n   = 1'b0;
		s_tdata  = '0;
		s_tlast  = 1'b0;
		s_tvalid = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		for (j = 0; j < 3; j++) begin
			force_acc[j]  = 0;
			torque_acc[j] = 0;
			center_pos[j] = 0;
		end

		// directed nodes, centre at its reset value
		// empty mesh closes with zero sums
		dir_tab.push_back('{mk_node(0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1,
			mk_res(0, 0, 0, 0, 0, 0)});
		// unit weight passes traction through, no lever
		dir_tab.push_back('{mk_node(ONE, 32'h0002_0000, 32'hFFFD_0000, ONE, 0, 0, 0, 1'b1),
			1'b1, mk_res(48'h1_0000, 48'h2_0000, 48'hFFFF_FFFD_0000, 0, 0, 0)});
		// unit lever along y, force along x gives negative z torque
		dir_tab.push_back('{mk_node(ONE, 0, 0, ONE, 0, ONE, 0, 1'b1), 1'b1,
			mk_res(48'h1_0000, 0, 0, 0, 0, 48'hFFFF_FFFF_0000)});
		// half weight on one lsb: ties round up
		dir_tab.push_back('{mk_node(1, 32'hFFFF_FFFF, 3, 32'h0000_8000, 0, 0, 0, 1'b1),
			1'b1, mk_res(1, 0, 2, 0, 0, 0)});
		// nodal force clamps to 32 bits both ways
		dir_tab.push_back('{mk_node(MAXV, MINV, 0, WMAX, 0, 0, 0, 1'b1), 1'b1,
			mk_res(48'h0000_7FFF_FFFF, 48'hFFFF_8000_0000, 0, 0, 0, 0)});
		// zero weight kills any traction and lever
		dir_tab.push_back('{mk_node(MAXV, MINV, MAXV, 0, MAXV, MINV, MAXV, 1'b1), 1'b1,
			mk_res(0, 0, 0, 0, 0, 0)});
		// torque x runs into the positive clamp, then backs off from it
		for (j = 0; j < 3; j++)
			dir_tab.push_back('{mk_node(MAXV, MAXV, MAXV, WMAX, 0, MAXV, MINV, 1'b0),
				1'b0, '0});
		dir_tab.push_back('{mk_node(MAXV, MAXV, MAXV, WMAX, 0, MINV, MAXV, 1'b1), 1'b0, '0});
		// torque x runs into the negative clamp, then a small node on top
		for (j = 0; j < 3; j++)
			dir_tab.push_back('{mk_node(MAXV, MAXV, MAXV, WMAX, 0, MINV, MAXV, 1'b0),
				1'b0, '0});
		dir_tab.push_back('{mk_node(ONE, ONE, ONE, ONE, ONE, 0, 0, 1'b1), 1'b0, '0});
		// multi-node mesh with positions at the extremes
		dir_tab.push_back('{mk_node(32'h0001_2345, 32'hFFF9_8766, 32'h0002_468A,
			32'h0001_8000, MAXV, MINV, ONE, 1'b0), 1'b0, '0});
		dir_tab.push_back('{mk_node(MINV, MINV, MINV, ONE, MINV, MINV, MINV, 1'b0),
			1'b0, '0});
		dir_tab.push_back('{mk_node(32'hFFFF_0000, 32'h0003_0000, MAXV, WMAX,
			MAXV, MAXV, MAXV, 1'b1), 1'b0, '0});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[k])
			send_node(dir_tab[k].nd, dir_tab[k].typed, dir_tab[k].res);

		// random meshes under each centre setting
		for (p = 0; p < N_PHASES; p++) begin
			drain_results();
			no_idle = (p == N_PHASES - 1);
			write_reg(REG_CENTER_X, (p == RAND_PHASE) ? $urandom() : CENTER_SETS[p][0]);
			write_reg(REG_CENTER_Y, (p == RAND_PHASE) ? $urandom() : CENTER_SETS[p][1]);
			write_reg(REG_CENTER_Z, (p == RAND_PHASE) ? $urandom() : CENTER_SETS[p][2]);
			if (p == 2)
				write_reg(REG_NONE, $urandom());
			// long output hold while single-node meshes keep coming
			if (p == 0)
				hold_req = 1'b1;
			paused = 1'b0;
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if (p == 1 && !paused && sent >= ITEMS_PER_PHASE / 2) begin
					paused = 1'b1;
					drain_results();
				end
				if (p == 0 && sent < HOLD_ITEMS)
					len = 1;
				else if ($urandom_range(0, 9) == 0)
					len = $urandom_range(10, 40);
				else
					len = $urandom_range(1, 6);
				for (j = 0; j < len; j++) begin
					nd = mk_node(rand_val(), rand_val(), rand_val(), rand_weight(),
						rand_val(), rand_val(), rand_val(), j == len - 1);
					send_node(nd, 1'b0, '0);
					sent++;
				end
			end
		end

		drain_results();
		if (n_mismatch == 0 && expected_sums.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/sfti_pkg.sv
hw/rtl/sfti_front.sv
hw/rtl/sfti_back.sv
hw/rtl/surface_force_torque_integrator.sv
sim/tb_surface_force_torque_integrator.sv
